// ===== rtl/e2r_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler 3-2-1 to
// rotation matrix block. Used by every module in rtl/.
package e2r_pkg;

	localparam int AngleBits   = 16;
	localparam int ElementBits = 16;
	localparam int PhaseBits   = 32;
	localparam int PhasePad    = PhaseBits - AngleBits;
	localparam int CordicIters = 32;
	localparam int XyBits      = 34;
	localparam int ZBits       = 33;
	localparam int TrigBits    = 32;
	localparam int SumBits     = 33;
	localparam int StageBits   = 5;

	localparam logic signed [XyBits-1:0] CordicStart = XyBits'(652032874);
	localparam logic signed [TrigBits-1:0] OneQ30 = TrigBits'(1073741824);

	typedef struct packed {
		logic [1:0]               quad;
		logic signed [XyBits-1:0] x;
		logic signed [XyBits-1:0] y;
		logic signed [ZBits-1:0]  z;
	} lane_t;

	// lane 0 roll, lane 1 pitch, lane 2 yaw
	typedef struct packed {
		lane_t [2:0] lane;
	} cord_t;

	typedef struct packed {
		logic signed [TrigBits-1:0] c;
		logic signed [TrigBits-1:0] s;
	} sc_t;

	function automatic logic [29:0] atan_phase(input logic [StageBits-1:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0:  r = 30'h20000000;
			5'd1:  r = 30'h12E4051E;
			5'd2:  r = 30'h09FB385B;
			5'd3:  r = 30'h051111D4;
			5'd4:  r = 30'h028B0D43;
			5'd5:  r = 30'h0145D7E1;
			5'd6:  r = 30'h00A2F61E;
			5'd7:  r = 30'h00517C55;
			5'd8:  r = 30'h0028BE53;
			5'd9:  r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			5'd24: r = 30'h00000029;
			5'd25: r = 30'h00000014;
			5'd26: r = 30'h0000000A;
			5'd27: r = 30'h00000005;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			5'd30: r = 30'h00000001;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [TrigBits-1:0] clamp_unit(
		input logic signed [XyBits-1:0] v);
		logic signed [XyBits-1:0] hi;
		logic signed [XyBits-1:0] lo;
		logic signed [TrigBits-1:0] r;
		hi = XyBits'(OneQ30);
		lo = -hi;
		if (v > hi)
			r = OneQ30;
		else if (v < lo)
			r = -OneQ30;
		else
			r = v[TrigBits-1:0];
		return r;
	endfunction

	// clamp CORDIC output and fold in the quadrant
	function automatic sc_t quad_map(input lane_t l);
		logic signed [TrigBits-1:0] c;
		logic signed [TrigBits-1:0] s;
		sc_t r;
		c = clamp_unit(l.x);
		s = clamp_unit(l.y);
		case (l.quad)
			2'd0: begin r.c = c;  r.s = s;  end
			2'd1: begin r.c = -s; r.s = c;  end
			2'd2: begin r.c = -c; r.s = -s; end
			default: begin r.c = s; r.s = -c; end
		endcase
		return r;
	endfunction

	// Q2.30 product rounded half up
	function automatic logic signed [TrigBits-1:0] mulq(
		input logic signed [TrigBits-1:0] a,
		input logic signed [TrigBits-1:0] b);
		logic signed [2*TrigBits-1:0] ae;
		logic signed [2*TrigBits-1:0] be;
		logic signed [2*TrigBits-1:0] p;
		ae = a;
		be = b;
		p = ae * be + (64'sd1 <<< 29);
		p = p >>> 30;
		return p[TrigBits-1:0];
	endfunction

	function automatic logic [ElementBits-1:0] to_element(
		input logic signed [SumBits-1:0] v);
		logic signed [SumBits-1:0] r;
		logic signed [SumBits-1:0] hi;
		logic signed [SumBits-1:0] lo;
		logic [ElementBits-1:0] e;
		hi = (SumBits'(1) <<< (ElementBits - 1)) - SumBits'(1);
		lo = -hi - SumBits'(1);
		r = (v + (SumBits'(1) <<< (PhaseBits - ElementBits - 2))) >>>
			(PhaseBits - ElementBits - 1);
		if (r > hi)
			e = hi[ElementBits-1:0];
		else if (r < lo)
			e = lo[ElementBits-1:0];
		else
			e = r[ElementBits-1:0];
		return e;
	endfunction

endpackage

// ===== rtl/e2r_cordic_cell.sv =====
// One CORDIC rotation step for the three angle lanes, with its own
// valid/ready register. Depends on e2r_pkg.
module e2r_cordic_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [e2r_pkg::StageBits-1:0]   stage,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  e2r_pkg::cord_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output e2r_pkg::cord_t                  out_data
);

	logic           valid_q;
	e2r_pkg::cord_t data_q;
	e2r_pkg::cord_t nxt;
	logic signed [e2r_pkg::ZBits-1:0] ang;

	assign ang = e2r_pkg::ZBits'(e2r_pkg::atan_phase(stage));

	always_comb begin
		nxt = in_data;
		for (int k = 0; k < 3; k++) begin
			if (!in_data.lane[k].z[e2r_pkg::ZBits-1]) begin
				nxt.lane[k].x = in_data.lane[k].x - (in_data.lane[k].y >>> stage);
				nxt.lane[k].y = in_data.lane[k].y + (in_data.lane[k].x >>> stage);
				nxt.lane[k].z = in_data.lane[k].z - ang;
			end else begin
				nxt.lane[k].x = in_data.lane[k].x + (in_data.lane[k].y >>> stage);
				nxt.lane[k].y = in_data.lane[k].y - (in_data.lane[k].x >>> stage);
				nxt.lane[k].z = in_data.lane[k].z + ang;
			end
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== rtl/e2r_matrix.sv =====
// Trig fold, two multiply stages and the output stage that sums, rounds,
// saturates and optionally transposes the matrix. Depends on e2r_pkg.
module e2r_matrix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           direction,
	input  logic           in_valid,
	output logic           in_ready,
	input  e2r_pkg::cord_t in_data,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [143:0]   m_axis_tdata
);

	localparam int W = e2r_pkg::TrigBits;
	localparam int S = e2r_pkg::SumBits;
	localparam int E = e2r_pkg::ElementBits;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	e2r_pkg::sc_t r_s1, p_s1, y_s1;

	logic signed [W-1:0] cysp_s2, sysp_s2, cycp_s2, sycp_s2, sycr_s2, sysr_s2;
	logic signed [W-1:0] cycr_s2, cysr_s2, cpsr_s2, cpcr_s2, sp_s2, sr_s2, cr_s2;

	logic signed [W-1:0] a_s3, b_s3, c_s3, d_s3;
	logic signed [W-1:0] cycp_s3, sycp_s3, sycr_s3, sysr_s3;
	logic signed [W-1:0] cycr_s3, cysr_s3, cpsr_s3, cpcr_s3, sp_s3;

	logic [E-1:0] m_s4 [9];
	logic [E-1:0] e [9];
	logic signed [S-1:0] sm [9];

	assign adv4 = !v_s4 || m_axis_tready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// row-major sums before rounding
	always_comb begin
		sm[0] = S'(cycp_s3);
		sm[1] = S'(a_s3) - S'(sycr_s3);
		sm[2] = S'(b_s3) + S'(sysr_s3);
		sm[3] = S'(sycp_s3);
		sm[4] = S'(c_s3) + S'(cycr_s3);
		sm[5] = S'(d_s3) - S'(cysr_s3);
		sm[6] = -S'(sp_s3);
		sm[7] = S'(cpsr_s3);
		sm[8] = S'(cpcr_s3);
		for (int k = 0; k < 9; k++) begin
			e[k] = e2r_pkg::to_element(sm[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			r_s1 <= e2r_pkg::quad_map(in_data.lane[0]);
			p_s1 <= e2r_pkg::quad_map(in_data.lane[1]);
			y_s1 <= e2r_pkg::quad_map(in_data.lane[2]);
		end
		if (adv2) begin
			cysp_s2 <= e2r_pkg::mulq(y_s1.c, p_s1.s);
			sysp_s2 <= e2r_pkg::mulq(y_s1.s, p_s1.s);
			cycp_s2 <= e2r_pkg::mulq(y_s1.c, p_s1.c);
			sycp_s2 <= e2r_pkg::mulq(y_s1.s, p_s1.c);
			sycr_s2 <= e2r_pkg::mulq(y_s1.s, r_s1.c);
			sysr_s2 <= e2r_pkg::mulq(y_s1.s, r_s1.s);
			cycr_s2 <= e2r_pkg::mulq(y_s1.c, r_s1.c);
			cysr_s2 <= e2r_pkg::mulq(y_s1.c, r_s1.s);
			cpsr_s2 <= e2r_pkg::mulq(p_s1.c, r_s1.s);
			cpcr_s2 <= e2r_pkg::mulq(p_s1.c, r_s1.c);
			sp_s2   <= p_s1.s;
			sr_s2   <= r_s1.s;
			cr_s2   <= r_s1.c;
		end
		if (adv3) begin
			a_s3    <= e2r_pkg::mulq(cysp_s2, sr_s2);
			b_s3    <= e2r_pkg::mulq(cysp_s2, cr_s2);
			c_s3    <= e2r_pkg::mulq(sysp_s2, sr_s2);
			d_s3    <= e2r_pkg::mulq(sysp_s2, cr_s2);
			cycp_s3 <= cycp_s2;
			sycp_s3 <= sycp_s2;
			sycr_s3 <= sycr_s2;
			sysr_s3 <= sysr_s2;
			cycr_s3 <= cycr_s2;
			cysr_s3 <= cysr_s2;
			cpsr_s3 <= cpsr_s2;
			cpcr_s3 <= cpcr_s2;
			sp_s3   <= sp_s2;
		end
		if (adv4) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_s4[i*3+j] <= direction ? e[j*3+i] : e[i*3+j];
				end
			end
		end
	end

	assign m_axis_tvalid = v_s4;
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			m_axis_tdata[k*E +: E] = m_s4[k];
		end
	end

endmodule

// ===== rtl/euler_321_to_rotation_matrix.sv =====
// Top level: Euler 3-2-1 angles to rotation matrix. Instantiates a chain of
// e2r_cordic_cell and the e2r_matrix back end. Depends on e2r_pkg.
//
// channel   dir  handshake                      payload
// s_axis    in   tvalid/tready                  roll, pitch, yaw (16b each)
// m_axis    out  tvalid/tready                  m00..m22 (16b each, Q1.15)
// cfg       in   cfg_wen                        direction (1b)
//
// One transaction per cycle in, one out, unless m_axis stalls; stages: 32 CORDIC
// cells, trig fold, two multiply stages, output stage. Each stage holds its own
// valid bit and accepts when empty or when its neighbor advances, so bubbles
// close up under stalls. Reset clears all valid bits and direction.
module euler_321_to_rotation_matrix (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [0:0]   cfg_wdata,      // direction
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,   // roll, pitch, yaw
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata    // m00,m01,m02,m10,m11,m12,m20,m21,m22
);

	localparam int N = e2r_pkg::CordicIters;

	logic           direction_q;
	logic           cv [N+1];
	logic           cr [N+1];
	e2r_pkg::cord_t cd [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_wen) begin
			direction_q <= cfg_wdata[0];
		end
	end

	// scale each angle to a 32-bit phase; top two bits pick the quadrant
	always_comb begin
		logic [e2r_pkg::PhaseBits-1:0] ph;
		for (int k = 0; k < 3; k++) begin
			ph = {s_axis_tdata[k*e2r_pkg::AngleBits +: e2r_pkg::AngleBits],
				{e2r_pkg::PhasePad{1'b0}}};
			cd[0].lane[k].quad = ph[31:30];
			cd[0].lane[k].x    = e2r_pkg::CordicStart;
			cd[0].lane[k].y    = '0;
			cd[0].lane[k].z    = e2r_pkg::ZBits'(ph[29:0]);
		end
	end

	assign cv[0] = s_axis_tvalid;
	assign s_axis_tready = cr[0];

	for (genvar g = 0; g < N; g++) begin : g_cell
		e2r_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage     (e2r_pkg::StageBits'(g)),
			.in_valid  (cv[g]),
			.in_ready  (cr[g]),
			.in_data   (cd[g]),
			.out_valid (cv[g+1]),
			.out_ready (cr[g+1]),
			.out_data  (cd[g+1])
		);
	end

	e2r_matrix u_matrix (
		.clk           (clk),
		.arst_n        (arst_n),
		.direction     (direction_q),
		.in_valid      (cv[N]),
		.in_ready      (cr[N]),
		.in_data       (cd[N]),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
